### hdl/assert_macros.svh
// Assertion macros used by the top level of the indexed list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define CHECK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Check that cons holds in the cycle after ante.
`define CHECK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHECK_SAME(lbl, clk, rst, ante, cons)
`define CHECK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/ile_pkg.sv
// Types and constants of the indexed list engine.
`default_nettype none
package ile_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_SET    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_GET    = 3'd4,
    MODE_FIND   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_INS   = 3'd1,
    CELL_DEL   = 3'd2,
    CELL_SET   = 3'd3,
    CELL_MATCH = 3'd4,
    CELL_SCAN  = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [VALUE_W-1:0]   value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]                mode;
    logic [4:0]                index;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] data;
    logic [3:0]                position;
    logic [4:0]                count;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] head_value;
    logic signed [VALUE_W-1:0] tail_value;
  } out_word_t;

endpackage
`default_nettype wire

### hdl/indexed_list_engine.sv
// Top level of the indexed list engine: controller, chain of cells and result register.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | mode, index, value
//  rsp     | out       | rsp_valid / rsp_ready | ok, data, position, count,
//          |           |                       | is_empty, head_value, tail_value
//
// One word is worked at a time: accept, execute (all cells shift or load at
// once), build the result word. Find latches a match flag in every cell and
// then shifts the flags down the chain one cell a cycle until a match reaches
// the head or the whole list has been scanned.
// A finished word waits in the result register while the next request is
// taken. Reset empties the list; cell contents are left as they are.
`default_nettype none
`include "assert_macros.svh"
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);     // element count width
  localparam int PW = (CW > 5) ? CW : 5;        // position compare width

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       k;          // scan position
  in_word_t            req_q;
  logic                res_ok;
  logic [VALUE_W-1:0]  res_data;
  logic [3:0]          res_pos;

  cell_ctrl_t          ctrl;
  logic [PW-1:0]       pos;
  logic [PW-1:0]       last;
  logic [PW-1:0]       cnt_p;
  logic [PW-1:0]       idx_p;
  logic                full;
  logic                ok_x;
  logic [VALUE_W-1:0]  rd_or;
  logic [VALUE_W-1:0]  tl_or;
  logic [VALUE_W-1:0]  head_x;
  logic [VALUE_W-1:0]  tail_x;
  logic                scan_end;
  logic                scan_hit;
  logic                rsp_free;

  logic [VALUE_W-1:0]  elem_a  [CAPACITY];
  logic                match_a [CAPACITY];
  logic [VALUE_W-1:0]  rd_a    [CAPACITY];
  logic [VALUE_W-1:0]  tl_a    [CAPACITY];

  // Chain of cells: each hands its element and match flag to its neighbours.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_v;
    logic [VALUE_W-1:0] right_v;
    logic               right_m;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = elem_a[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_v = '0;
      assign right_m = 1'b0;
    end else begin : g_inner
      assign right_v = elem_a[i+1];
      assign right_m = match_a[i+1];
    end
    ile_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (pos),
      .last        (last),
      .left        (left_v),
      .right       (right_v),
      .right_match (right_m),
      .elem        (elem_a[i]),
      .match       (match_a[i]),
      .rd          (rd_a[i]),
      .tl          (tl_a[i])
    );
  end

  // Gather the one-hot read outputs of the cells.
  always_comb begin
    rd_or = '0;
    tl_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_a[i];
      tl_or = tl_or | tl_a[i];
    end
  end

  assign cnt_p    = PW'(count);
  assign idx_p    = PW'(req_q.index);
  assign last     = cnt_p - 1'b1;
  assign full     = (count == CW'(CAPACITY));
  assign scan_end = (k == count);
  assign scan_hit = !scan_end && match_a[0];
  assign rsp_free = !rsp_valid || rsp_ready;
  assign head_x   = (count != '0) ? elem_a[0] : '0;
  assign tail_x   = (count != '0) ? tl_or : '0;
  assign req_ready = (state == S_IDLE);

  // Decode the held request into a cell operation and the new count.
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = req_q.value;
    pos        = idx_p;
    ok_x       = 1'b0;
    count_next = count;
    if (state == S_EXEC) begin
      case (req_q.mode)
        MODE_APPEND: begin
          if (!full) begin
            ctrl.op    = CELL_INS;
            pos        = cnt_p;
            ok_x       = 1'b1;
            count_next = CW'(count + 1'b1);
          end
        end
        MODE_INSERT: begin
          if (!full && idx_p <= cnt_p) begin
            ctrl.op    = CELL_INS;
            ok_x       = 1'b1;
            count_next = CW'(count + 1'b1);
          end
        end
        MODE_SET: begin
          if (idx_p < cnt_p) begin
            ctrl.op = CELL_SET;
            ok_x    = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (idx_p < cnt_p) begin
            ctrl.op    = CELL_DEL;
            ok_x       = 1'b1;
            count_next = CW'(count - 1'b1);
          end
        end
        MODE_GET: begin
          ok_x = (idx_p < cnt_p);
        end
        MODE_FIND: begin
          ctrl.op = CELL_MATCH;
        end
        MODE_CLEAR: begin
          ok_x       = 1'b1;
          count_next = '0;
        end
        default: ;
      endcase
    end else if (state == S_SCAN && !scan_end && !match_a[0]) begin
      // advance the match flags one cell towards the head
      ctrl.op = CELL_SCAN;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // load a finished word, else drop the one just taken
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count <= count_next;
          k     <= '0;
          state <= (req_q.mode == MODE_FIND) ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (scan_end || match_a[0]) begin
            state <= S_DONE;
          end else begin
            k <= CW'(k + 1'b1);
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_EXEC) begin
      res_ok   <= ok_x;
      res_pos  <= '0;
      // data is read before the cells shift, so remove returns the old element
      res_data <= (ok_x && (req_q.mode == MODE_GET || req_q.mode == MODE_REMOVE))
                  ? rd_or : '0;
    end
    if (state == S_SCAN && scan_hit) begin
      res_ok  <= 1'b1;
      res_pos <= 4'(k);
    end
    if (state == S_DONE && rsp_free) begin
      rsp.ok         <= res_ok;
      rsp.data       <= res_data;
      rsp.position   <= res_pos;
      rsp.count      <= 5'(count);
      rsp.is_empty   <= (count == '0);
      rsp.head_value <= head_x;
      rsp.tail_value <= tail_x;
    end
  end

  // The count never passes the capacity.
  `CHECK_SAME(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY))
  // An accepted request is executed in the next cycle.
  `CHECK_NEXT(a_accept_exec, clk, rst, req_valid && req_ready, state == S_EXEC)
  // A finished word waits while the output register is still occupied.
  `CHECK_NEXT(a_done_hold, clk, rst, state == S_DONE && rsp_valid && !rsp_ready,
              state == S_DONE)

endmodule
`default_nettype wire

### hdl/ile_cell.sv
// One storage cell of the list chain: holds one element and one match flag.
`default_nettype none
module ile_cell
  import ile_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PW  = 5
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [PW-1:0]      pos,
  input  logic [PW-1:0]      last,
  input  logic [VALUE_W-1:0] left,
  input  logic [VALUE_W-1:0] right,
  input  logic               right_match,
  output logic [VALUE_W-1:0] elem,
  output logic               match,
  output logic [VALUE_W-1:0] rd,
  output logic [VALUE_W-1:0] tl
);

  localparam logic [PW-1:0] MY = PW'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INS: begin
        // open a gap at pos: cells above take their left neighbour
        if (MY > pos) begin
          elem <= left;
        end else if (MY == pos) begin
          elem <= ctrl.value;
        end
      end
      CELL_DEL: begin
        if (MY >= pos) begin
          elem <= right;
        end
      end
      CELL_SET: begin
        if (MY == pos) begin
          elem <= ctrl.value;
        end
      end
      CELL_MATCH: match <= (elem == ctrl.value);
      CELL_SCAN:  match <= right_match;
      default: ;
    endcase
  end

  assign rd = (MY == pos)  ? elem : '0;
  assign tl = (MY == last) ? elem : '0;

endmodule
`default_nettype wire
